[rtl/wfc_pkg.sv]
// Package for the word frequency counter: shared types and constants.
// Depends on nothing.
`timescale 1ns / 1ps
package wfc_pkg;
	localparam logic [7:0] LC_A = 8'h61;
	localparam logic [7:0] LC_Z = 8'h7a;
	localparam logic [7:0] UC_A = 8'h41;
	localparam logic [7:0] UC_Z = 8'h5a;

	typedef enum logic [0:0] {
		ACT_TEXT = 1'b0,
		ACT_READ = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_WORD  = 2'd1,
		CMD_LONG  = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [63:0] word;
		logic [3:0]  len;
		logic [7:0]  index;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_WAIT,
		ST_COMPARE,
		ST_RDWAIT,
		ST_RDOUT
	} back_state_t;

	function automatic logic is_letter(input logic [7:0] c);
		is_letter = (c >= LC_A && c <= LC_Z) || (c >= UC_A && c <= UC_Z);
	endfunction
endpackage

[rtl/wfc_front.sv]
// Front end: collects letters into the pending word and emits word, too-long and read jobs.
// Depends on wfc_pkg.
`timescale 1ns / 1ps
module wfc_front #(
	parameter int MAX_WORD_LEN = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             action,
	input  logic [7:0]       char_code,
	input  logic [7:0]       entry_index,
	input  logic             job_ready,
	output logic             in_ready,
	output logic             job_valid,
	output wfc_pkg::job_t    job
);
	localparam logic [3:0] LIMIT = 4'(MAX_WORD_LEN);
	logic [63:0] word_q;
	logic [3:0]  len_q;
	logic        letter;
	logic        emit;

	assign letter = wfc_pkg::is_letter(char_code);
	always_comb begin
		job.word  = word_q;
		job.len   = len_q;
		job.index = entry_index;
		if (action == wfc_pkg::ACT_READ) begin
			job.cmd = wfc_pkg::CMD_READ;
		end else if (letter || len_q == 4'd0) begin
			job.cmd = wfc_pkg::CMD_NONE;
		end else if (len_q > LIMIT) begin
			job.cmd = wfc_pkg::CMD_LONG;
		end else begin
			job.cmd = wfc_pkg::CMD_WORD;
		end
	end
	assign emit      = job.cmd != wfc_pkg::CMD_NONE;
	assign job_valid = in_valid && emit;
	assign in_ready  = !emit || job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
			len_q  <= '0;
		end else if (in_valid && in_ready && action == wfc_pkg::ACT_TEXT) begin
			if (letter) begin
				if (len_q < LIMIT) begin
					word_q <= word_q | (64'(char_code) << {len_q[2:0], 3'b000});
					len_q  <= len_q + 4'd1;
				end else begin
					len_q <= LIMIT + 4'd1;
				end
			end else begin
				word_q <= '0;
				len_q  <= '0;
			end
		end
	end
endmodule

[rtl/wfc_queue.sv]
// Two-entry job queue between front and back end.
// Depends on wfc_pkg.
`timescale 1ns / 1ps
module wfc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	input  wfc_pkg::job_t wr_job,
	output logic          wr_ready,
	output logic          rd_valid,
	output wfc_pkg::job_t rd_job,
	input  logic          rd_ready
);
	wfc_pkg::job_t slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_job   = slot_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wp_q] <= wr_job;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= !wp_q;
			end
			if (rd) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule

[rtl/wfc_back.sv]
// Back end: sequential table search, update, append and entry reads.
// Depends on wfc_pkg; holds the table memory.
`timescale 1ns / 1ps
module wfc_back #(
	parameter int TABLE_DEPTH = 256,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   job_valid,
	input  wfc_pkg::job_t          job,
	output logic                   job_ready,
	output logic                   res_valid,
	input  logic                   res_ready,
	output logic [63:0]            entry_word,
	output logic [3:0]             entry_length,
	output logic [15:0]            entry_count,
	output logic                   entry_valid,
	output logic [8:0]             distinct_words,
	output logic                   word_too_long,
	output logic                   table_full
);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int UW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = 64 + 4 + COUNT_WIDTH;
	localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

	logic [EW-1:0] mem [TABLE_DEPTH];
	logic [EW-1:0] rdata_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [EW-1:0] mem_wd;

	wfc_pkg::back_state_t state_q, state_d;
	logic [UW-1:0] used_q, used_d;
	logic [UW-1:0] ptr_q, ptr_d;
	logic          long_q, long_d, full_q, full_d;
	logic [63:0]   wword_q;
	logic [3:0]    wlen_q;
	logic [7:0]    ridx_q;
	logic          take;
	logic          hit;
	logic [COUNT_WIDTH-1:0] rcount;

	assign rcount = rdata_q[COUNT_WIDTH-1:0];
	assign hit = rdata_q[EW-1:COUNT_WIDTH] == {wword_q, wlen_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[mem_ra];
		if (take) begin
			wword_q <= job.word;
			wlen_q  <= job.len;
			ridx_q  <= job.index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wfc_pkg::ST_IDLE;
			used_q  <= '0;
			ptr_q   <= '0;
			long_q  <= 1'b0;
			full_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			ptr_q   <= ptr_d;
			long_q  <= long_d;
			full_q  <= full_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		used_d    = used_q;
		ptr_d     = ptr_q;
		long_d    = long_q;
		full_d    = full_q;
		job_ready = 1'b0;
		take      = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_wa    = ptr_q[AW-1:0];
		mem_ra    = ptr_q[AW-1:0];
		mem_wd    = {wword_q, wlen_q, COUNT_WIDTH'(1)};
		unique case (state_q)
			wfc_pkg::ST_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					take = 1'b1;
					ptr_d = '0;
					unique case (job.cmd)
						wfc_pkg::CMD_LONG: long_d = 1'b1;
						wfc_pkg::CMD_WORD: state_d = wfc_pkg::ST_SEARCH;
						wfc_pkg::CMD_READ: state_d = wfc_pkg::ST_RDWAIT;
						default: state_d = wfc_pkg::ST_IDLE;
					endcase
				end
			end
			wfc_pkg::ST_SEARCH: begin
				if (ptr_q == used_q) begin
					state_d = wfc_pkg::ST_IDLE;
					if (used_q == UW'(TABLE_DEPTH)) begin
						full_d = 1'b1;
					end else begin
						mem_we = 1'b1;
						used_d = used_q + UW'(1);
					end
				end else begin
					state_d = wfc_pkg::ST_WAIT;
				end
			end
			wfc_pkg::ST_WAIT: begin
				state_d = wfc_pkg::ST_COMPARE;
			end
			wfc_pkg::ST_COMPARE: begin
				if (hit) begin
					state_d = wfc_pkg::ST_IDLE;
					if (rcount != CMAX) begin
						mem_we = 1'b1;
						mem_wd = {rdata_q[EW-1:COUNT_WIDTH], rcount + COUNT_WIDTH'(1)};
					end
				end else begin
					ptr_d   = ptr_q + UW'(1);
					state_d = wfc_pkg::ST_SEARCH;
				end
			end
			wfc_pkg::ST_RDWAIT: begin
				mem_ra  = AW'(ridx_q);
				state_d = wfc_pkg::ST_RDOUT;
			end
			wfc_pkg::ST_RDOUT: begin
				mem_ra    = AW'(ridx_q);
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = wfc_pkg::ST_IDLE;
				end
			end
			default: state_d = wfc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		entry_valid = (32'(ridx_q) < 32'(used_q)) && (32'(ridx_q) < 32'(TABLE_DEPTH));
		entry_word     = entry_valid ? rdata_q[EW-1:COUNT_WIDTH+4] : 64'd0;
		entry_length   = entry_valid ? rdata_q[COUNT_WIDTH+3:COUNT_WIDTH] : 4'd0;
		entry_count    = entry_valid ? 16'(rcount) : 16'd0;
		distinct_words = 9'(used_q);
		word_too_long  = long_q;
		table_full     = full_q;
	end
endmodule

[rtl/word_frequency_counter.sv]
// Top level of the word frequency counter: front end, job queue, back end.
// Depends on wfc_pkg, wfc_front, wfc_queue, wfc_back.
//
// channel | direction | handshake   | fields
// input   | in        | push, full  | action, char_code, entry_index
// result  | out       | pop, empty  | entry_word .. table_full
//
// Letters are never stalled. A word end or read goes to the back end, which scans
// the table through one memory read port, one stored entry at a time. Reset
// clears counters and flags only; the table needs no clearing. A full queue
// stalls word ends and reads; pending results stall the back end.
`timescale 1ns / 1ps
module word_frequency_counter #(
	parameter int TABLE_DEPTH  = 256,
	parameter int MAX_WORD_LEN = 8,
	parameter int COUNT_WIDTH  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic [7:0]  char_code,
	input  logic [7:0]  entry_index,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] entry_word,
	output logic [3:0]  entry_length,
	output logic [15:0] entry_count,
	output logic        entry_valid,
	output logic [8:0]  distinct_words,
	output logic        word_too_long,
	output logic        table_full
);
	logic          in_ready, fj_valid, fj_ready, bj_valid, bj_ready, res_valid;
	wfc_pkg::job_t fjob, bjob;

	assign full  = !in_ready;
	assign empty = !res_valid;

	wfc_front #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_front (
		.clk, .arst_n, .in_valid(push), .action, .char_code, .entry_index,
		.job_ready(fj_ready), .in_ready, .job_valid(fj_valid), .job(fjob)
	);
	wfc_queue u_queue (
		.clk, .arst_n, .wr_valid(fj_valid), .wr_job(fjob), .wr_ready(fj_ready),
		.rd_valid(bj_valid), .rd_job(bjob), .rd_ready(bj_ready)
	);
	wfc_back #(.TABLE_DEPTH(TABLE_DEPTH), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk, .arst_n, .job_valid(bj_valid), .job(bjob), .job_ready(bj_ready),
		.res_valid, .res_ready(pop), .entry_word, .entry_length, .entry_count,
		.entry_valid, .distinct_words, .word_too_long, .table_full
	);

	a_flag_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		word_too_long |=> word_too_long) else $error("too-long flag dropped");
	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		table_full |=> table_full) else $error("full flag dropped");
	a_used_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> distinct_words >= $past(distinct_words)) else $error("count fell");
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(entry_word) && $stable(entry_count)))
		else $error("result changed while waiting");
endmodule

[sim/tb.sv]
// Testbench for word_frequency_counter: directed words, repeat counts, table fill,
// and random text with reads, checked against a scoreboard of expected table reads.
// Depends on wfc_pkg and rtl/word_frequency_counter.sv.
`timescale 1ns / 1ps
module tb;
	localparam int DEPTH     = 256;
	localparam int MAX_LEN   = 8;
	localparam int COUNT_MAX = 65535;
	localparam int STALL_CAP = 40000;

	typedef struct {
		logic [63:0] word;
		logic [3:0]  len;
		logic [15:0] count;
		logic        valid;
		logic [8:0]  distinct;
		logic        too_long;
		logic        full_flag;
	} table_read_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        push = 0;
	logic        full;
	logic        action = wfc_pkg::ACT_TEXT;
	logic [7:0]  char_code = 0;
	logic [7:0]  entry_index = 0;
	logic        empty;
	logic        pop = 0;
	logic [63:0] entry_word;
	logic [3:0]  entry_length;
	logic [15:0] entry_count;
	logic        entry_valid;
	logic [8:0]  distinct_words;
	logic        word_too_long;
	logic        table_full;

	word_frequency_counter uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .action(action),
		.char_code(char_code), .entry_index(entry_index), .empty(empty), .pop(pop),
		.entry_word(entry_word), .entry_length(entry_length), .entry_count(entry_count),
		.entry_valid(entry_valid), .distinct_words(distinct_words),
		.word_too_long(word_too_long), .table_full(table_full)
	);

	// predicted block state
	logic [63:0] cur_word;
	int          cur_len;
	logic [63:0] tab_word [DEPTH];
	int          tab_len [DEPTH];
	int          tab_count [DEPTH];
	int          used;
	logic        long_seen;
	logic        full_seen;

	table_read_t expected_reads[$];
	int          errors = 0;
	int          send_idle = 0;
	int          recv_stall = 0;
	int          quiet = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit letter(input logic [7:0] c);
		return (c >= wfc_pkg::LC_A && c <= wfc_pkg::LC_Z)
			|| (c >= wfc_pkg::UC_A && c <= wfc_pkg::UC_Z);
	endfunction

	task automatic close_word();
		bit hit;
		hit = 0;
		if (cur_len > MAX_LEN)
			long_seen = 1;
		else if (cur_len > 0) begin
			for (int i = 0; i < used && !hit; i++)
				if (tab_len[i] == cur_len && tab_word[i] == cur_word) begin
					if (tab_count[i] < COUNT_MAX)
						tab_count[i]++;
					hit = 1;
				end
			if (!hit) begin
				if (used < DEPTH) begin
					tab_word[used] = cur_word;
					tab_len[used] = cur_len;
					tab_count[used] = 1;
					used++;
				end else
					full_seen = 1;
			end
		end
		cur_word = 0;
		cur_len = 0;
	endtask

	task automatic predict_word(input wfc_pkg::action_t a, input logic [7:0] c,
			input logic [7:0] idx);
		table_read_t r;
		if (a == wfc_pkg::ACT_TEXT) begin
			if (!letter(c))
				close_word();
			else if (cur_len < MAX_LEN) begin
				cur_word |= 64'(c) << (8 * cur_len);
				cur_len++;
			end else
				cur_len = MAX_LEN + 1;
		end else begin
			r.valid = (idx < used);
			r.word = r.valid ? tab_word[idx] : 64'd0;
			r.len = r.valid ? 4'(tab_len[idx]) : 4'd0;
			r.count = r.valid ? 16'(tab_count[idx]) : 16'd0;
			r.distinct = 9'(used);
			r.too_long = long_seen;
			r.full_flag = full_seen;
			expected_reads.push_back(r);
		end
	endtask

	task automatic send(input wfc_pkg::action_t a, input logic [7:0] c, input logic [7:0] idx);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			push <= 0;
			@(negedge clk);
		end
		push <= 1;
		action <= a;
		char_code <= c;
		entry_index <= idx;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_word(a, c, idx);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send(wfc_pkg::ACT_TEXT, s[i], 8'($urandom));
	endtask

	task automatic read_entry(input logic [7:0] idx);
		send(wfc_pkg::ACT_READ, 8'($urandom), idx);
	endtask

	function automatic logic [7:0] any_letter(input bit narrow);
		logic [7:0] c;
		if (narrow)
			c = $urandom_range(0, 1) ? 8'(wfc_pkg::LC_A + $urandom_range(0, 2))
			                         : 8'(wfc_pkg::UC_Z - $urandom_range(0, 1));
		else
			c = $urandom_range(0, 1) ? 8'(wfc_pkg::LC_A + $urandom_range(0, 25))
			                         : 8'(wfc_pkg::UC_A + $urandom_range(0, 25));
		return c;
	endfunction

	function automatic logic [7:0] fill_letter(input int k);
		return (k < 26) ? 8'(wfc_pkg::LC_A + k) : 8'(wfc_pkg::UC_A + k - 26);
	endfunction

	function automatic logic [7:0] separator();
		logic [7:0] c;
		c = 8'($urandom);
		while (letter(c))
			c = 8'($urandom);
		return c;
	endfunction

	task automatic send_word(input int n, input bit narrow);
		for (int i = 0; i < n; i++)
			send(wfc_pkg::ACT_TEXT, any_letter(narrow), 8'($urandom));
		send(wfc_pkg::ACT_TEXT, separator(), 8'($urandom));
	endtask

	// hold input until every read has come back and the back end has settled
	task automatic drain();
		@(negedge clk);
		push <= 0;
		while (expected_reads.size() != 0)
			@(posedge clk);
		repeat (900) @(posedge clk);
	endtask

	always @(negedge clk)
		pop <= ($urandom_range(0, 99) >= recv_stall);

	always @(posedge clk) begin
		if (pop && !empty) begin
			if (expected_reads.size() == 0) begin
				$display("%0t: unexpected word: actual word=%h", $time, entry_word);
				errors++;
			end else begin
				table_read_t e;
				e = expected_reads.pop_front();
				if (e.word !== entry_word || e.len !== entry_length || e.count !== entry_count
						|| e.valid !== entry_valid || e.distinct !== distinct_words
						|| e.too_long !== word_too_long || e.full_flag !== table_full) begin
					$display({"%0t: mismatch expected %h/%0d/%0d/%b/%0d/%b/%b",
						" actual %h/%0d/%0d/%b/%0d/%b/%b"},
						$time, e.word, e.len, e.count, e.valid, e.distinct, e.too_long,
						e.full_flag, entry_word, entry_length, entry_count, entry_valid,
						distinct_words, word_too_long, table_full);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_CAP) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic test_directed();
		read_entry(8'd0);
		send_text("a Zz,ABCDEFGH");
		send(wfc_pkg::ACT_TEXT, 8'h00, 8'hff);
		send_text("ABCDEFGHIJ@a");
		read_entry(8'd1);
		send(wfc_pkg::ACT_TEXT, 8'hff, 8'h00);
		send_text("A[`{a");
		read_entry(8'd0);
		send_text("zZ ");
		for (int i = 0; i < 5; i++)
			read_entry(8'(i));
		read_entry(8'hff);
	endtask

	task automatic test_repeat_count();
		for (int i = 0; i < 10; i++)
			send_text("a ");
		read_entry(8'd0);
	endtask

	task automatic test_random_text(input int n);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 65)
				send_word($urandom_range(1, 10), $urandom_range(0, 3) != 0);
			else if (r < 85)
				read_entry($urandom_range(0, 1) ? 8'($urandom_range(0, used + 2 > 255 ? 255
				                                                     : used + 2))
				                                 : 8'($urandom));
			else
				send(wfc_pkg::ACT_TEXT, 8'($urandom), 8'($urandom));
		end
	endtask

	task automatic test_table_fill();
		int n;
		n = 0;
		while (used < DEPTH) begin
			if (n >= 52)
				send(wfc_pkg::ACT_TEXT, fill_letter(n / 52 - 1), 8'($urandom));
			send(wfc_pkg::ACT_TEXT, fill_letter(n % 52), 8'($urandom));
			send(wfc_pkg::ACT_TEXT, separator(), 8'($urandom));
			n++;
		end
		for (int i = 0; i < 4; i++)
			send_word(8, 0);
		send_text("a ");
		read_entry(8'd0);
		read_entry(8'd255);
		read_entry(8'd128);
	endtask

	initial begin
		cur_word = 0;
		cur_len = 0;
		used = 0;
		long_seen = 0;
		full_seen = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		test_directed();
		test_repeat_count();
		send_idle = 66; recv_stall = 0;
		test_random_text(25);
		drain();
		send_idle = 0; recv_stall = 66;
		test_random_text(25);
		send_idle = 28; recv_stall = 28;
		test_random_text(15);
		send_idle = 0; recv_stall = 0;
		test_table_fill();
		send_idle = 28; recv_stall = 28;
		test_random_text(10);
		send_idle = 0; recv_stall = 66;
		test_random_text(5);
		@(negedge clk);
		push <= 0;
		while (expected_reads.size() != 0)
			@(posedge clk);
		repeat (1000) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

[sim.f]
rtl/wfc_pkg.sv
rtl/wfc_front.sv
rtl/wfc_queue.sv
rtl/wfc_back.sv
rtl/word_frequency_counter.sv
sim/tb.sv
